>>> sv/towr_pkg.sv
// Shared types and constants for the tiled, offset, wrapped coordinate remapper.
// Depends on nothing; imported by towr_axis and tile_offset_wrap_coordinate_remap.
package towr_pkg;

   // Fixed point and frame limits.
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 12;
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_SIZE   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SIZE_W     = $clog2(MAX_SIZE + 1);

   // Register widths.
   localparam int SIZE_REG_W  = 13;
   localparam int TILES_W     = 21;
   localparam int ANCHOR_W    = 17;
   localparam int SHIFT_W     = 18;
   localparam int CSR_DATA_W  = 21;
   localparam int CSR_INDEX_W = 3;

   // Datapath widths derived from the above.
   localparam int QUOT_W  = COORD_W + FRAC_BITS;
   localparam int DIFF_W  = QUOT_W + 1;
   localparam int PROD_W  = 2 * FRAC_BITS;
   localparam int SCALE_W = FRAC_BITS + SIZE_W;

   // Reset values of the registers.
   localparam logic [SIZE_W-1:0]   WIDTH_RESET  = SIZE_W'(1920);
   localparam logic [SIZE_W-1:0]   HEIGHT_RESET = SIZE_W'(1080);
   localparam logic [TILES_W-1:0]  TILES_RESET  = TILES_W'(65536);
   localparam logic [ANCHOR_W-1:0] ANCHOR_RESET = ANCHOR_W'(32768);
   localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = '0;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_HORIZ_TILES  = 3'd2,
      CSR_VERT_TILES   = 3'd3,
      CSR_ANCHOR_X     = 3'd4,
      CSR_ANCHOR_Y     = 3'd5,
      CSR_SHIFT_X      = 3'd6,
      CSR_SHIFT_Y      = 3'd7
   } towr_csr_type;

   // Settings that one axis pipeline needs.
   typedef struct packed {
      logic [SIZE_W-1:0]   size;
      logic [TILES_W-1:0]  tiles;
      logic [ANCHOR_W-1:0] anchor;
      logic [SHIFT_W-1:0]  shift;
   } towr_axis_cfg_type;

endpackage

>>> sv/towr_axis.sv
// One axis of the remapper: a pipelined restoring divider followed by the
// anchor, tiling, offset, wrap and rescale stages. Depends on towr_pkg.
module towr_axis import towr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               pipe_en,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] in_pos,
   input  towr_axis_cfg_type  cfg,
   output logic               out_valid,
   output logic [COORD_W-1:0] out_index
);

   localparam int DIV_STAGES = QUOT_W;
   localparam int ST_DIFF    = DIV_STAGES + 1;
   localparam int ST_PROD    = DIV_STAGES + 2;
   localparam int ST_FRAC    = DIV_STAGES + 3;
   localparam int ST_SCALE   = DIV_STAGES + 4;

   logic [ST_SCALE:0]   vld_ff;
   logic [ST_SCALE:0]   vld_in;

   logic [SIZE_W-1:0]   rem_ff [0:DIV_STAGES];
   logic [SIZE_W-1:0]   rem_in [0:DIV_STAGES];
   logic [QUOT_W-1:0]   nq_ff  [0:DIV_STAGES];
   logic [QUOT_W-1:0]   nq_in  [0:DIV_STAGES];
   logic [SIZE_W:0]     div_trial [0:DIV_STAGES-1];

   logic [DIFF_W-1:0]   diff_ff, diff_in;
   logic [PROD_W-1:0]   diff_ext;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                neg_ff;
   logic [PROD_W-1:0]   biased;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [SIZE_W-1:0]   raw_index;
   logic [SIZE_W-1:0]   size_last;

   // Valid bits move one stage per enabled cycle.
   assign vld_in = {vld_ff[ST_SCALE-1:0], in_valid};

   // Divider: one quotient bit per stage, numerator is the position in Q16.
   always_comb begin
      rem_in[0] = '0;
      nq_in[0]  = {in_pos, {FRAC_BITS{1'b0}}};
      for (int k = 0; k < DIV_STAGES; k++) begin
         div_trial[k] = {rem_ff[k], nq_ff[k][QUOT_W-1]};
         if (div_trial[k] >= {1'b0, cfg.size}) begin
            rem_in[k+1] = SIZE_W'(div_trial[k] - {1'b0, cfg.size});
            nq_in[k+1]  = {nq_ff[k][QUOT_W-2:0], 1'b1};
         end else begin
            rem_in[k+1] = div_trial[k][SIZE_W-1:0];
            nq_in[k+1]  = {nq_ff[k][QUOT_W-2:0], 1'b0};
         end
      end
   end

   // Distance from the anchor, signed.
   assign diff_in = {1'b0, nq_ff[DIV_STAGES]} - DIFF_W'(cfg.anchor);

   // Tiling product; only its low bits reach the wrapped fraction.
   assign diff_ext = {{(PROD_W - DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
   assign prod_in  = diff_ext * PROD_W'(cfg.tiles);

   // Truncation toward zero: a negative product rounds up, so add the
   // fraction mask before dropping the fraction bits. Wrap keeps low bits.
   assign biased  = prod_ff + (neg_ff ? PROD_W'({FRAC_BITS{1'b1}}) : '0);
   assign frac_in = biased[FRAC_BITS +: FRAC_BITS] + cfg.anchor[FRAC_BITS-1:0]
                    + cfg.shift[FRAC_BITS-1:0];

   // Back to pixels.
   assign scale_in = SCALE_W'(frac_ff) * SCALE_W'(cfg.size);

   // Guard clamp to the last pixel of the axis.
   assign raw_index = scale_ff[FRAC_BITS +: SIZE_W];
   assign size_last = cfg.size - SIZE_W'(1);
   assign out_index = (raw_index > size_last) ? COORD_W'(size_last) : COORD_W'(raw_index);
   assign out_valid = vld_ff[ST_SCALE];

   // Valid chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
         end
         diff_ff  <= diff_in;
         prod_ff  <= prod_in;
         neg_ff   <= diff_ff[DIFF_W-1];
         frac_ff  <= frac_in;
         scale_ff <= scale_in;
      end
   end

endmodule

>>> sv/tile_offset_wrap_coordinate_remap.sv
// Tiled, offset, repeat-wrapped coordinate remapper, top level.
// Throughput: one request per cycle while the output queue has room, set by the
// one-bit-per-stage divider pipeline. A two-entry output queue lets requests in
// while a result waits; while it is full the whole pipeline holds until a result
// has left. Synchronous reset empties the pipeline and queue and loads the register
// reset values. Depends on towr_pkg and towr_axis.
module tile_offset_wrap_coordinate_remap import towr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_W-1:0]     req_out_col,
   input  logic [COORD_W-1:0]     req_out_row,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_W-1:0]     rsp_src_col,
   output logic [COORD_W-1:0]     rsp_src_row,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   logic [SIZE_W-1:0]   width_ff, height_ff;
   logic [TILES_W-1:0]  htiles_ff, vtiles_ff;
   logic [ANCHOR_W-1:0] anchor_x_ff, anchor_y_ff;
   logic [SHIFT_W-1:0]  shift_x_ff, shift_y_ff;
   towr_axis_cfg_type   cfg_x, cfg_y;

   logic                pipe_en;
   logic                col_valid, row_valid;
   logic [COORD_W-1:0]  col_index, row_index;

   logic [COORD_W-1:0]  fifo_col_ff [0:FIFO_DEPTH-1];
   logic [COORD_W-1:0]  fifo_row_ff [0:FIFO_DEPTH-1];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                fifo_wr, fifo_rd;

   // A size of zero acts as one, a size past the maximum as the maximum.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_REG_W-1:0] raw,
                                                  input int limit);
      logic [SIZE_W-1:0] result;
      if (raw == '0) begin
         result = SIZE_W'(1);
      end else if (int'(raw) > limit) begin
         result = SIZE_W'(limit);
      end else begin
         result = SIZE_W'(raw);
      end
      return result;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         htiles_ff   <= TILES_RESET;
         vtiles_ff   <= TILES_RESET;
         anchor_x_ff <= ANCHOR_RESET;
         anchor_y_ff <= ANCHOR_RESET;
         shift_x_ff  <= SHIFT_RESET;
         shift_y_ff  <= SHIFT_RESET;
      end else if (csr_write) begin
         unique case (towr_csr_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff    <= eff_size(csr_data[SIZE_REG_W-1:0], MAX_WIDTH);
            CSR_IMAGE_HEIGHT: height_ff   <= eff_size(csr_data[SIZE_REG_W-1:0], MAX_HEIGHT);
            CSR_HORIZ_TILES:  htiles_ff   <= csr_data[TILES_W-1:0];
            CSR_VERT_TILES:   vtiles_ff   <= csr_data[TILES_W-1:0];
            CSR_ANCHOR_X:     anchor_x_ff <= csr_data[ANCHOR_W-1:0];
            CSR_ANCHOR_Y:     anchor_y_ff <= csr_data[ANCHOR_W-1:0];
            CSR_SHIFT_X:      shift_x_ff  <= csr_data[SHIFT_W-1:0];
            CSR_SHIFT_Y:      shift_y_ff  <= csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg_x = '{size: width_ff, tiles: htiles_ff, anchor: anchor_x_ff, shift: shift_x_ff};
   assign cfg_y = '{size: height_ff, tiles: vtiles_ff, anchor: anchor_y_ff, shift: shift_y_ff};

   // The pipeline moves whenever the output queue has room.
   assign pipe_en   = (cnt_ff < CNT_W'(FIFO_DEPTH));
   assign req_stall = !pipe_en;

   towr_axis u_axis_col (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (req_valid),
      .in_pos    (req_out_col),
      .cfg       (cfg_x),
      .out_valid (col_valid),
      .out_index (col_index)
   );

   towr_axis u_axis_row (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (req_valid),
      .in_pos    (req_out_row),
      .cfg       (cfg_y),
      .out_valid (row_valid),
      .out_index (row_index)
   );

   // Output queue.
   assign fifo_wr = col_valid && pipe_en;
   assign fifo_rd = rsp_valid && !rsp_stall;

   always_comb begin
      cnt_in = cnt_ff;
      if (fifo_wr && !fifo_rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (fifo_rd && !fifo_wr) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (fifo_wr) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (fifo_rd) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_col_ff[wr_ptr_ff] <= col_index;
         fifo_row_ff[wr_ptr_ff] <= row_index;
      end
   end

   assign rsp_valid   = (cnt_ff != '0);
   assign rsp_src_col = fifo_col_ff[rd_ptr_ff];
   assign rsp_src_row = fifo_row_ff[rd_ptr_ff];

   // Both axis pipelines carry the same requests in lockstep.
   a_axis_lockstep: assert property (@(posedge clock) disable iff (reset)
      col_valid == row_valid)
      else $error("axis pipelines out of step");

   // The queue never takes a result when it is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CNT_W'(FIFO_DEPTH)) |-> !fifo_wr)
      else $error("output queue overflow");

   // The queue count stays within its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("output queue count out of range");

   // While the pipeline holds, the queue cannot grow.
   a_hold_no_growth: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> cnt_ff <= $past(cnt_ff))
      else $error("queue grew while pipeline held");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for tile_offset_wrap_coordinate_remap.
// It predicts each source coordinate in its own fixed-point model and checks it against the
// block under random valid/stall pressure. Depends on towr_pkg and the remapper RTL.
`timescale 1ns / 100ps

module testbench;
   import towr_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int TAIL_CYCLES     = 48;

   // One full set of register values, held at the register widths.
   typedef struct {
      logic [SIZE_REG_W-1:0] width;
      logic [SIZE_REG_W-1:0] height;
      logic [TILES_W-1:0]    h_tiles;
      logic [TILES_W-1:0]    v_tiles;
      logic [ANCHOR_W-1:0]   anchor_x;
      logic [ANCHOR_W-1:0]   anchor_y;
      logic [SHIFT_W-1:0]    shift_x;
      logic [SHIFT_W-1:0]    shift_y;
   } remap_settings_type;

   typedef struct {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } source_point_type;

   // Predicts source coordinates and checks the block's results in order.
   class remap_scoreboard;
      remap_settings_type regs;
      source_point_type   expected_sources[$];
      int                 mismatch_count;
      int                 requests_seen;
      int                 results_checked;

      function new();
         regs.width    = WIDTH_RESET;
         regs.height   = HEIGHT_RESET;
         regs.h_tiles  = TILES_RESET;
         regs.v_tiles  = TILES_RESET;
         regs.anchor_x = ANCHOR_RESET;
         regs.anchor_y = ANCHOR_RESET;
         regs.shift_x  = SHIFT_RESET;
         regs.shift_y  = SHIFT_RESET;
         mismatch_count  = 0;
         requests_seen   = 0;
         results_checked = 0;
      endfunction

      // A size of zero acts as one; anything past the maximum acts as the maximum.
      static function int effective_size(logic [SIZE_REG_W-1:0] size_reg, int limit);
         if (size_reg == 0)
            return 1;
         if (int'(size_reg) > limit)
            return limit;
         return int'(size_reg);
      endfunction

      function void set_register(towr_csr_type index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_IMAGE_WIDTH:  regs.width    = data[SIZE_REG_W-1:0];
            CSR_IMAGE_HEIGHT: regs.height   = data[SIZE_REG_W-1:0];
            CSR_HORIZ_TILES:  regs.h_tiles  = data[TILES_W-1:0];
            CSR_VERT_TILES:   regs.v_tiles  = data[TILES_W-1:0];
            CSR_ANCHOR_X:     regs.anchor_x = data[ANCHOR_W-1:0];
            CSR_ANCHOR_Y:     regs.anchor_y = data[ANCHOR_W-1:0];
            CSR_SHIFT_X:      regs.shift_x  = data[SHIFT_W-1:0];
            CSR_SHIFT_Y:      regs.shift_y  = data[SHIFT_W-1:0];
            default: ;
         endcase
      endfunction

      // Normalise, scale about the anchor, add the shift, keep the fraction, back to pixels.
      function logic [COORD_W-1:0] fold_axis(logic [COORD_W-1:0] pos, int size,
                                             logic [TILES_W-1:0] tiles,
                                             logic [ANCHOR_W-1:0] anchor,
                                             logic [SHIFT_W-1:0] shift);
         longint norm, scaled, whole, frac, idx;
         norm   = (longint'(pos) << FRAC_BITS) / longint'(size);
         scaled = (norm - longint'(anchor)) * longint'(tiles);
         // The product is truncated toward zero, not floored.
         if (scaled < 0)
            whole = -((-scaled) >>> FRAC_BITS);
         else
            whole = scaled >>> FRAC_BITS;
         whole = whole + longint'(anchor) + longint'($signed(shift));
         frac  = longint'(whole[FRAC_BITS-1:0]);
         idx   = (frac * longint'(size)) >>> FRAC_BITS;
         if (idx > longint'(size) - 1)
            idx = longint'(size) - 1;
         return idx[COORD_W-1:0];
      endfunction

      function void note_request(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         source_point_type pt;
         pt.col = fold_axis(col, effective_size(regs.width, MAX_WIDTH), regs.h_tiles,
                            regs.anchor_x, regs.shift_x);
         pt.row = fold_axis(row, effective_size(regs.height, MAX_HEIGHT), regs.v_tiles,
                            regs.anchor_y, regs.shift_y);
         expected_sources.push_back(pt);
         requests_seen++;
      endfunction

      function void check_result(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         source_point_type pt;
         if (expected_sources.size() == 0) begin
            $error("result with no request outstanding: src_col %0d src_row %0d", col, row);
            mismatch_count++;
            return;
         end
         pt = expected_sources.pop_front();
         results_checked++;
         if (col !== pt.col) begin
            $error("src_col mismatch: expected %0d, actual %0d", pt.col, col);
            mismatch_count++;
         end
         if (row !== pt.row) begin
            $error("src_row mismatch: expected %0d, actual %0d", pt.row, row);
            mismatch_count++;
         end
      endfunction

      function int pending();
         return expected_sources.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [COORD_W-1:0]     req_out_col = '0;
   logic [COORD_W-1:0]     req_out_row = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COORD_W-1:0]     rsp_src_col;
   logic [COORD_W-1:0]     rsp_src_row;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   remap_scoreboard board = new();
   bit              quiet_run = 1'b0;
   int              stall_hold = 0;
   int              stall_roll;
   int              settings_loaded = 0;

   tile_offset_wrap_coordinate_remap dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_out_col (req_out_col),
      .req_out_row (req_out_row),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_src_col (rsp_src_col),
      .rsp_src_row (rsp_src_row),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Result side: check what was taken at this edge, then pick the next stall level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_src_col, rsp_src_row);
      if (quiet_run) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 55) begin
            rsp_stall <= 1'b0;
            stall_hold = $urandom_range(0, 20);
         end else if (stall_roll < 93) begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(10, 50);
         end
      end
   end

   // Gap after a request: mostly none or short, now and then long.
   function automatic int idle_gap();
      int roll;
      if (quiet_run)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Keeps the low bits of a register value and may fill the unused upper bits with noise.
   function automatic logic [CSR_DATA_W-1:0] pad_word(logic [CSR_DATA_W-1:0] value, int bits,
                                                      bit noisy);
      logic [CSR_DATA_W-1:0] keep;
      keep = (CSR_DATA_W'(1) << bits) - 1'b1;
      if (noisy)
         return (value & keep) | (CSR_DATA_W'($urandom()) & ~keep);
      return value & keep;
   endfunction

   function automatic remap_settings_type make_settings(int w, int h, int ht, int vt,
                                                        int ax, int ay, int sx, int sy);
      remap_settings_type cfg;
      cfg.width    = SIZE_REG_W'(w);
      cfg.height   = SIZE_REG_W'(h);
      cfg.h_tiles  = TILES_W'(ht);
      cfg.v_tiles  = TILES_W'(vt);
      cfg.anchor_x = ANCHOR_W'(ax);
      cfg.anchor_y = ANCHOR_W'(ay);
      cfg.shift_x  = SHIFT_W'(sx);
      cfg.shift_y  = SHIFT_W'(sy);
      return cfg;
   endfunction

   // Random settings that lean on the corners: zero and oversize frames, zero and huge
   // tile counts, anchors and shifts at and past their stated limits.
   function automatic remap_settings_type random_settings();
      remap_settings_type cfg;
      logic [SIZE_REG_W-1:0] sizes [2];
      logic [TILES_W-1:0]    tiles [2];
      logic [ANCHOR_W-1:0]   anchors [2];
      logic [SHIFT_W-1:0]    shifts [2];
      for (int a = 0; a < 2; a++) begin
         case ($urandom_range(0, 9))
            0:       sizes[a] = '0;
            1:       sizes[a] = SIZE_REG_W'($urandom_range(4097, 8191));
            2:       sizes[a] = SIZE_REG_W'($urandom_range(1, 2));
            3:       sizes[a] = SIZE_REG_W'(4096);
            default: sizes[a] = SIZE_REG_W'($urandom_range(1, 4096));
         endcase
         case ($urandom_range(0, 9))
            0:       tiles[a] = '0;
            1:       tiles[a] = TILES_W'($urandom());
            2:       tiles[a] = TILES_W'(6554);
            3:       tiles[a] = TILES_W'(1310720);
            4:       tiles[a] = TILES_W'(65536);
            default: tiles[a] = TILES_W'($urandom_range(6554, 1310720));
         endcase
         case ($urandom_range(0, 7))
            0:       anchors[a] = '0;
            1:       anchors[a] = ANCHOR_W'(65536);
            2:       anchors[a] = ANCHOR_W'($urandom());
            default: anchors[a] = ANCHOR_W'($urandom_range(0, 65536));
         endcase
         case ($urandom_range(0, 9))
            0:       shifts[a] = SHIFT_W'(-65536);
            1:       shifts[a] = SHIFT_W'(65536);
            2:       shifts[a] = SHIFT_W'($urandom());
            3:       shifts[a] = '0;
            default: shifts[a] = SHIFT_W'($urandom_range(0, 131072) - 65536);
         endcase
      end
      cfg.width    = sizes[0];
      cfg.height   = sizes[1];
      cfg.h_tiles  = tiles[0];
      cfg.v_tiles  = tiles[1];
      cfg.anchor_x = anchors[0];
      cfg.anchor_y = anchors[1];
      cfg.shift_x  = shifts[0];
      cfg.shift_y  = shifts[1];
      return cfg;
   endfunction

   // Mostly inside the frame, sometimes on its last pixel or just past it, sometimes anywhere.
   function automatic logic [COORD_W-1:0] pick_coord(int span);
      case ($urandom_range(0, 9))
         0:       return COORD_W'(span - 1);
         1:       return (span < MAX_SIZE) ? COORD_W'(span) : COORD_W'($urandom());
         2, 3:    return COORD_W'($urandom());
         default: return COORD_W'($urandom_range(0, span - 1));
      endcase
   endfunction

   // Writes all eight registers back to back; only called while the block is idle.
   task automatic load_settings(input remap_settings_type cfg, input bit noisy);
      logic [CSR_DATA_W-1:0] word [8];
      word[CSR_IMAGE_WIDTH]  = pad_word(CSR_DATA_W'(cfg.width), SIZE_REG_W, noisy);
      word[CSR_IMAGE_HEIGHT] = pad_word(CSR_DATA_W'(cfg.height), SIZE_REG_W, noisy);
      word[CSR_HORIZ_TILES]  = pad_word(CSR_DATA_W'(cfg.h_tiles), TILES_W, noisy);
      word[CSR_VERT_TILES]   = pad_word(CSR_DATA_W'(cfg.v_tiles), TILES_W, noisy);
      word[CSR_ANCHOR_X]     = pad_word(CSR_DATA_W'(cfg.anchor_x), ANCHOR_W, noisy);
      word[CSR_ANCHOR_Y]     = pad_word(CSR_DATA_W'(cfg.anchor_y), ANCHOR_W, noisy);
      word[CSR_SHIFT_X]      = pad_word(CSR_DATA_W'(cfg.shift_x), SHIFT_W, noisy);
      word[CSR_SHIFT_Y]      = pad_word(CSR_DATA_W'(cfg.shift_y), SHIFT_W, noisy);
      for (int i = 0; i < 8; i++) begin
         csr_write <= 1'b1;
         csr_index <= towr_csr_type'(i);
         csr_data  <= word[i];
         @(posedge clock);
         board.set_register(towr_csr_type'(i), word[i]);
      end
      csr_write <= 1'b0;
      settings_loaded++;
   endtask

   // Presents one request and holds it until the block takes it.
   task automatic send_request(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      int gap;
      req_valid   <= 1'b1;
      req_out_col <= col;
      req_out_row <= row;
      do @(posedge clock); while (req_stall);
      board.note_request(col, row);
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits for every predicted result to come back.
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      remap_settings_type cfg;
      int span_col;
      int span_row;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset values: frame corners, the edge just past the frame, alternating bits.
      send_request(12'd0, 12'd0);
      send_request(12'd4095, 12'd4095);
      send_request(12'd1919, 12'd1079);
      send_request(12'd1920, 12'd1080);
      send_request(12'd960, 12'd540);
      send_request(12'hAAA, 12'h555);
      send_request(12'h555, 12'hAAA);
      drain_requests();

      // Zero width, oversize height, zero and full-scale tiles, anchors and shifts at limits.
      load_settings(make_settings(0, 8191, 0, 'h1FFFFF, 0, 'h1FFFF, -65536, 'h1FFFF), 1'b0);
      send_request(12'd0, 12'd0);
      send_request(12'd4095, 12'd4095);
      send_request(12'd1, 12'd2048);
      send_request(12'd4095, 12'd0);
      drain_requests();

      // Largest width, one-pixel height, smallest and largest legal tile counts.
      load_settings(make_settings(4096, 1, 6554, 1310720, 65536, 0, 65536, 'h20000), 1'b1);
      send_request(12'd0, 12'd0);
      send_request(12'd4095, 12'd4095);
      send_request(12'd2048, 12'd1);
      send_request(12'd1, 12'd0);
      drain_requests();

      // Tiny width and a height just past the maximum, with a shift of one step back.
      load_settings(make_settings(3, 4097, 65536, 65536, 0, 0, 0, -1), 1'b0);
      send_request(12'd0, 12'd0);
      send_request(12'd2, 12'd4095);
      send_request(12'd3, 12'd2047);
      drain_requests();

      // Random settings, each followed by a burst of requests.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         cfg = random_settings();
         load_settings(cfg, ($urandom_range(0, 1) == 1));
         quiet_run = (ph % 4 == 1);
         span_col  = remap_scoreboard::effective_size(cfg.width, MAX_WIDTH);
         span_row  = remap_scoreboard::effective_size(cfg.height, MAX_HEIGHT);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // Now and then hold off until everything in flight has come back.
            if ((ph == 2 && k == ITEMS_PER_PHASE / 2) || $urandom_range(0, 399) == 0)
               drain_requests();
            send_request(pick_coord(span_col), pick_coord(span_row));
         end
         drain_requests();
         quiet_run = 1'b0;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d source coordinates from %0d requests under %0d register loads,",
               board.results_checked, board.requests_seen, settings_loaded);
      $display("including zero, oversize and out-of-range settings and idle/stall gaps.");
      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> tile_offset_wrap_coordinate_remap.f
sv/towr_pkg.sv
sv/towr_axis.sv
sv/tile_offset_wrap_coordinate_remap.sv
tb/testbench.sv
